// ----- rtl/core/hst_pkg.sv -----
package hst_pkg;

	localparam logic [1:0] KIND_KEY    = 2'd0;
	localparam logic [1:0] KIND_DATA   = 2'd1;
	localparam logic [1:0] KIND_FIN    = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [7:0] IPAD_BYTE = 8'h36;
	localparam logic [7:0] OPAD_BYTE = 8'h5c;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	typedef logic [7:0][31:0] hash_t;
	typedef logic [15:0][31:0] blk_t;
	typedef logic [3:0][63:0] key_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] key_word;
		logic [1:0]  key_index;
		logic [7:0]  data_byte;
	} item_t;

	// listed from word 7 down to word 0
	localparam hash_t SHA_IV = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	// 32 key bytes then 32 zero bytes, all xored with the pad byte
	function automatic blk_t key_block(input key_t key, input logic [7:0] pad);
		blk_t b;
		for (int i = 0; i < 16; i++) begin
			if (i < 8) begin
				b[i] = (i % 2 == 0) ? key[i / 2][63:32] : key[i / 2][31:0];
			end else begin
				b[i] = 32'd0;
			end
			b[i] = b[i] ^ {4{pad}};
		end
		return b;
	endfunction

endpackage

// ----- rtl/core/hst_front.sv -----
module hst_front
	import hst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] key_word,
	input  logic [1:0]  key_index,
	input  logic [7:0]  data_byte,
	output logic        q_valid,
	output item_t       q_item,
	input  logic        q_pop
);

	item_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QPTR_W:0]    count_q;
	logic               push;
	logic               pop;

	assign in_stall = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	// unused kind code is swallowed here and never reaches the back end
	assign push = in_valid && !in_stall && (kind != KIND_UNUSED);
	assign q_valid = (count_q != '0);
	assign pop = q_pop && q_valid;
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{kind: kind, key_word: key_word,
				key_index: key_index, data_byte: data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/core/hst_sha.sv -----
module hst_sha
	import hst_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  hash_t h_in,
	input  blk_t  blk,
	output logic  done,
	output hash_t digest
);

	hash_t       hin_q;
	hash_t       v_q;
	blk_t        w_q;
	logic [6:0]  rnd_q;
	logic        busy_q;
	logic        done_q;
	hash_t       dig_q;
	hash_t       v_n;
	logic [31:0] w_new;
	logic [31:0] t1;
	logic [31:0] t2;

	always_comb begin
		t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ SHA_K[rnd_q[5:0]] + w_q[0];
		t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		v_n[7] = v_q[6];
		v_n[6] = v_q[5];
		v_n[5] = v_q[4];
		v_n[4] = v_q[3] + t1;
		v_n[3] = v_q[2];
		v_n[2] = v_q[1];
		v_n[1] = v_q[0];
		v_n[0] = t1 + t2;
		w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hin_q <= h_in;
			v_q <= h_in;
			w_q <= blk;
		end else if (busy_q && !rnd_q[6]) begin
			v_q <= v_n;
			// rolling schedule window
			w_q <= {w_new, w_q[15:1]};
		end
		if (busy_q && rnd_q[6]) begin
			for (int i = 0; i < 8; i++) begin
				dig_q[i] <= hin_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rnd_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (rnd_q[6]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					rnd_q <= rnd_q + 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign digest = dig_q;

endmodule

// ----- rtl/core/hst_back.sv -----
module hst_back
	import hst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  item_t       q_item,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] tag_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_START  = 4'd1;
	localparam logic [3:0] S_EXEC   = 4'd2;
	localparam logic [3:0] S_BLK_GO = 4'd3;
	localparam logic [3:0] S_BLK    = 4'd4;
	localparam logic [3:0] S_PAD1   = 4'd5;
	localparam logic [3:0] S_PAD2   = 4'd6;
	localparam logic [3:0] S_OKEY   = 4'd7;
	localparam logic [3:0] S_OFIN   = 4'd8;
	localparam logic [3:0] S_OUT    = 4'd9;

	logic [3:0]  st_q;
	logic        started_q;
	logic [63:0] len_q;
	hash_t       chain_q;
	key_t        key_q;
	blk_t        buf_q;
	logic [1:0]  cur_kind_q;
	logic [7:0]  cur_byte_q;
	hash_t       tag_q;
	logic [1:0]  widx_q;
	logic        out_valid_q;
	logic [63:0] tag_word_q;
	logic [1:0]  word_index_q;
	logic        last_word_q;

	logic        sha_start;
	hash_t       sha_h;
	blk_t        sha_blk;
	logic        sha_done;
	hash_t       sha_dig;

	logic [5:0]  r;
	logic [63:0] bit_len;
	blk_t        pad_blk;
	blk_t        len_blk;
	blk_t        outer_blk;

	hst_sha u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sha_start),
		.h_in   (sha_h),
		.blk    (sha_blk),
		.done   (sha_done),
		.digest (sha_dig)
	);

	assign q_pop = (st_q == S_IDLE);
	assign r = len_q[5:0];

	// inner length counts the key block too
	always_comb begin
		logic [63:0] len_plus;
		len_plus = len_q + 64'd64;
		bit_len = {len_plus[60:0], 3'b000};
	end

	always_comb begin
		for (int p = 0; p < 64; p++) begin
			if (6'(p) < r) begin
				pad_blk[p / 4][(3 - p % 4) * 8 +: 8] = buf_q[p / 4][(3 - p % 4) * 8 +: 8];
			end else if (6'(p) == r) begin
				pad_blk[p / 4][(3 - p % 4) * 8 +: 8] = 8'h80;
			end else begin
				pad_blk[p / 4][(3 - p % 4) * 8 +: 8] = 8'h00;
			end
		end
		// length fits in this block only if fewer than 56 bytes are left
		if (r < 6'd56) begin
			pad_blk[14] = bit_len[63:32];
			pad_blk[15] = bit_len[31:0];
		end
		len_blk = '0;
		len_blk[14] = bit_len[63:32];
		len_blk[15] = bit_len[31:0];
		outer_blk = '0;
		for (int i = 0; i < 8; i++) begin
			outer_blk[i] = chain_q[i];
		end
		outer_blk[8] = 32'h8000_0000;
		outer_blk[15] = 32'd768;
	end

	always_comb begin
		sha_start = 1'b0;
		sha_h = chain_q;
		sha_blk = buf_q;
		case (st_q)
			S_IDLE: begin
				if (q_valid && q_item.kind != KIND_KEY && !started_q) begin
					sha_start = 1'b1;
					sha_h = SHA_IV;
					sha_blk = key_block(key_q, IPAD_BYTE);
				end
			end
			S_EXEC: begin
				if (cur_kind_q == KIND_FIN) begin
					sha_start = 1'b1;
					sha_blk = pad_blk;
				end
			end
			S_BLK_GO: begin
				sha_start = 1'b1;
			end
			S_PAD1: begin
				sha_start = sha_done;
				sha_h = sha_dig;
				sha_blk = len_blk;
			end
			S_PAD2: begin
				sha_start = sha_done;
				sha_h = SHA_IV;
				sha_blk = key_block(key_q, OPAD_BYTE);
			end
			S_OKEY: begin
				sha_start = sha_done;
				sha_h = sha_dig;
				sha_blk = outer_blk;
			end
			default: begin
				sha_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && q_valid) begin
			cur_kind_q <= q_item.kind;
			cur_byte_q <= q_item.data_byte;
		end
		if (st_q == S_EXEC && cur_kind_q == KIND_DATA) begin
			buf_q[len_q[5:2]][{~len_q[1:0], 3'b000} +: 8] <= cur_byte_q;
		end
		if (sha_done && (st_q == S_START || st_q == S_BLK || st_q == S_PAD1
				|| st_q == S_PAD2)) begin
			chain_q <= sha_dig;
		end
		if (sha_done && st_q == S_OFIN) begin
			tag_q <= sha_dig;
		end
		if (st_q == S_OUT && (!out_valid_q || !out_stall)) begin
			tag_word_q <= {tag_q[{widx_q, 1'b0}], tag_q[{widx_q, 1'b1}]};
			word_index_q <= widx_q;
			last_word_q <= (widx_q == 2'd3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			started_q <= 1'b0;
			len_q <= '0;
			key_q <= '0;
			widx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// while emitting, the valid flag is driven by the output state below
			if (!out_stall && st_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.kind == KIND_KEY) begin
							key_q[q_item.key_index] <= q_item.key_word;
						end else if (!started_q) begin
							st_q <= S_START;
						end else begin
							st_q <= S_EXEC;
						end
					end
				end
				S_START: begin
					if (sha_done) begin
						started_q <= 1'b1;
						len_q <= '0;
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (cur_kind_q == KIND_DATA) begin
						len_q <= len_q + 64'd1;
						st_q <= (len_q[5:0] == 6'd63) ? S_BLK_GO : S_IDLE;
					end else begin
						st_q <= (r >= 6'd56) ? S_PAD1 : S_PAD2;
					end
				end
				S_BLK_GO: begin
					st_q <= S_BLK;
				end
				S_BLK: begin
					if (sha_done) begin
						st_q <= S_IDLE;
					end
				end
				S_PAD1: begin
					if (sha_done) begin
						st_q <= S_PAD2;
					end
				end
				S_PAD2: begin
					if (sha_done) begin
						st_q <= S_OKEY;
					end
				end
				S_OKEY: begin
					if (sha_done) begin
						st_q <= S_OFIN;
					end
				end
				S_OFIN: begin
					if (sha_done) begin
						started_q <= 1'b0;
						len_q <= '0;
						widx_q <= '0;
						st_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						widx_q <= widx_q + 1'b1;
						if (widx_q == 2'd3) begin
							st_q <= S_IDLE;
						end
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign tag_word = tag_word_q;
	assign word_index = word_index_q;
	assign last_word = last_word_q;

endmodule

// ----- rtl/core/hmac_sha256_tag.sv -----
// HMAC-SHA256 with a 256-bit key loaded as four 64-bit words (kind 0), message
// bytes streamed one per transfer (kind 1) and a finish transfer (kind 2) that
// returns the 32-byte tag as four 64-bit words, the last one flagged. A four-entry
// queue decouples the input from the hashing engine, which runs one SHA-256
// round per cycle: each full 64-byte block of message bytes is compressed once
// it fills, the first byte or finish of a message first compresses the key block,
// and a finish compresses the padded block or blocks, the outer key block and the
// outer block before the first tag word. Keys persist across messages; kind 3 is dropped.
module hmac_sha256_tag
	import hst_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [63:0] key_word,
	input  logic [1:0]  key_index,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] tag_word,
	output logic [1:0]  word_index,
	output logic        last_word
);

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	hst_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.key_word  (key_word),
		.key_index (key_index),
		.data_byte (data_byte),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop)
	);

	hst_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.tag_word   (tag_word),
		.word_index (word_index),
		.last_word  (last_word)
	);

endmodule

// ----- rtl/core/hst_checker.sv -----
module hst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] tag_word,
	input logic [1:0]  word_index,
	input logic        last_word
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tag_word))
		else $error("stalled tag word dropped or changed");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_word == (word_index == 2'd3)))
		else $error("last flag does not match word position");

	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_word |=>
			out_valid && (word_index == $past(word_index) + 2'd1))
		else $error("tag words not back to back in order");

	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_word |=> !out_valid)
		else $error("tag word after last word");

endmodule

bind hmac_sha256_tag hst_checker u_hst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.tag_word   (tag_word),
	.word_index (word_index),
	.last_word  (last_word)
);
